// File: design/rca_pkg.sv
package rca_pkg;

    // fixed field widths
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_STEP     = 1'b1;

    // register reset values
    localparam logic [7:0]  CAP_RESET  = 8'd115;
    localparam logic [15:0] STEP_RESET = 16'd655;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIVW,
        ST_HUE,
        ST_PREP,
        ST_WEIGH,
        ST_SUM,
        ST_CHECK,
        ST_STEP,
        ST_PQT,
        ST_LOADC,
        ST_OUT
    } ctrl_state_t;

    // what the shared divider is working on
    typedef enum logic {
        JOB_SAT,
        JOB_HUE
    } div_job_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_start;
        div_job_t div_job;
        logic     hue;
        logic     prep;
        logic     step;
        logic     dir_up;
        logic     pqt;
        logic     loadc;
        logic     weigh;
        logic     sum;
        logic     out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic bright_lt;
        logic bright_gt;
        logic v_ok;
        logic out_full;
    } sts_t;

endpackage

// File: design/rca_if.sv
interface rca_in_if;
    logic                        valid;
    logic                        ready;
    logic [rca_pkg::COLOR_W-1:0] color_in;

    modport source (output valid, output color_in, input ready);
    modport sink (input valid, input color_in, output ready);
endinterface

interface rca_out_if;
    logic                        valid;
    logic                        ready;
    logic [rca_pkg::COLOR_W-1:0] color_out;

    modport source (output valid, output color_out, input ready);
    modport sink (input valid, input color_out, output ready);
endinterface

// File: design/rca_div.sv
module rca_div #(
    parameter int QW = 17,
    parameter int VW = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VW+QW-1:0] dividend,
    input  logic [VW-1:0]    divisor,
    output logic             busy,
    output logic             done,
    output logic [QW-1:0]    quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // one quotient bit a cycle, restoring
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[VW+QW-1:QW];
            sh_next   = dividend[QW-1:0];
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
            sh_next  = {sh_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

// File: design/rca_datapath.sv
module rca_datapath #(
    parameter int F = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rca_pkg::cmd_t                  cmd,
    output rca_pkg::sts_t                  sts,
    input  logic [rca_pkg::COLOR_W-1:0]    color_in,
    output logic [rca_pkg::COLOR_W-1:0]    color_out,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int QW  = F + 1;
    localparam int VW  = F + 3;
    localparam int DVW = VW + QW;
    localparam int CWD = F + 2;
    localparam int MW  = 2 * F + 3;
    localparam int WW  = F + 8;
    localparam int PW  = 2 * F + 10;
    localparam int SW  = 2 * F + 12;
    localparam int BW  = F + 12;
    localparam int XW  = F + 10;

    localparam logic [63:0] WR_FULL = (64'd76245 * (64'd1 << F) + 64'd500) / 64'd1000;
    localparam logic [63:0] WG_FULL = (64'd149685 * (64'd1 << F) + 64'd500) / 64'd1000;
    localparam logic [63:0] WB_FULL = (64'd29070 * (64'd1 << F) + 64'd500) / 64'd1000;
    localparam logic [WW-1:0] WR = WR_FULL[WW-1:0];
    localparam logic [WW-1:0] WG = WG_FULL[WW-1:0];
    localparam logic [WW-1:0] WB = WB_FULL[WW-1:0];

    localparam logic [F:0]    ONE_C  = {1'b1, {F{1'b0}}};
    localparam logic [CWD-1:0] ONE_W = {2'b01, {F{1'b0}}};
    localparam logic [XW-1:0] HALF   = XW'(1) << (F - 1);

    // configuration registers
    logic [7:0]  cap_reg;
    logic [15:0] vstep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= rca_pkg::CAP_RESET;
            vstep_reg <= rca_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rca_pkg::CFG_BRIGHTNESS_CAP: cap_reg   <= cfg_data[7:0];
                rca_pkg::CFG_VALUE_STEP:     vstep_reg <= cfg_data;
                default:                     cap_reg   <= cap_reg;
            endcase
        end
    end

    logic [rca_pkg::COLOR_W-1:0] word_reg;
    logic [CWD-1:0] c0_reg, c1_reg, c2_reg;
    logic [F:0]     hi_reg, d_reg, s_reg, h_reg;
    logic [VW-1:0]  n_reg;
    logic signed [F+2:0] v_reg;
    logic [F:0]     a1_reg, a2_reg, a3_reg;
    logic [2:0]     sector_reg;
    logic [CWD-1:0] vv_reg, p_reg, q_reg, t_reg;
    logic [PW-1:0]  pr_reg, pg_reg, pb_reg;
    logic [BW-1:0]  bright_reg;
    logic [rca_pkg::COLOR_W-1:0] out_reg;
    logic           out_valid_reg;

    // byte to Q1.F channel, rounded to nearest
    logic [F:0] byte_fx [256];

    for (genvar b = 0; b < 256; b++)
    begin : g_byte_fx
        localparam logic [63:0] BFX = (64'(b) * (64'd1 << F) + 64'd127) / 64'd255;
        assign byte_fx[b] = BFX[F:0];
    end

    // divider operands by job
    logic [DVW-1:0] dividend;
    logic [VW-1:0]  divisor;
    logic [QW-1:0]  quotient;
    logic           div_busy, div_done;

    always_comb
    begin
        dividend = '0;
        divisor  = '0;
        case (cmd.div_job)
            rca_pkg::JOB_SAT:
            begin
                dividend = DVW'(d_reg) << F;
                divisor  = VW'(hi_reg);
            end
            default:
            begin
                dividend = DVW'(n_reg) << F;
                divisor  = (VW'(d_reg) << 2) + (VW'(d_reg) << 1);
            end
        endcase
    end

    rca_div #(.QW(QW), .VW(VW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // max, min, range and hue numerator
    logic [CWD-1:0] hi_c, lo_c;
    logic [VW-1:0]  dd, dd6, c0w, c1w, c2w, n_c;

    always_comb
    begin
        hi_c = c0_reg;
        lo_c = c0_reg;
        if (c1_reg > hi_c) hi_c = c1_reg;
        if (c1_reg < lo_c) lo_c = c1_reg;
        if (c2_reg > hi_c) hi_c = c2_reg;
        if (c2_reg < lo_c) lo_c = c2_reg;
        dd  = VW'(hi_c - lo_c);
        dd6 = (dd << 2) + (dd << 1);
        c0w = VW'(c0_reg);
        c1w = VW'(c1_reg);
        c2w = VW'(c2_reg);
        if (hi_c == c0_reg)
            n_c = (c1_reg >= c2_reg) ? c1w - c2w : dd6 - (c2w - c1w);
        else if (hi_c == c1_reg)
            n_c = (dd << 1) + c2w - c0w;
        else
            n_c = (dd << 2) + c0w - c1w;
    end

    // hue sector, fraction and per-item factors
    logic [F+3:0]   h6;
    logic [3:0]     sec;
    logic [F-1:0]   frac;
    logic [F:0]     omf;
    logic [2*F+1:0] fs1, fs2;

    always_comb
    begin
        h6   = ((F+4)'(h_reg) << 2) + ((F+4)'(h_reg) << 1);
        sec  = h6[F+3:F];
        frac = h6[F-1:0];
        omf  = ONE_C - {1'b0, frac};
        fs1  = (2*F+2)'(frac) * (2*F+2)'(s_reg);
        fs2  = (2*F+2)'(omf) * (2*F+2)'(s_reg);
    end

    // step and new value
    logic [F+15:0]       step_wide;
    logic [F-1:0]        step_c;
    logic signed [F+2:0] step_s;

    always_comb
    begin
        step_wide = {vstep_reg, {F{1'b0}}};
        step_c    = step_wide[F+15:16];
        if (step_c == '0)
            step_c = F'(1);
        step_s = $signed({3'b000, step_c});
    end

    // p, q, t products
    logic [CWD-1:0] vv_c;
    logic [MW-1:0]  mp, mq, mt;

    always_comb
    begin
        vv_c = v_reg[F+2] ? '0 : v_reg[F+1:0];
        mp   = MW'(vv_c) * MW'(a1_reg);
        mq   = MW'(vv_c) * MW'(a2_reg);
        mt   = MW'(vv_c) * MW'(a3_reg);
    end

    // brightness sum
    logic [SW-1:0] bsum;
    logic [BW-1:0] cap_fx;

    assign bsum   = SW'(pr_reg) + SW'(pg_reg) + SW'(pb_reg);
    assign cap_fx = BW'({cap_reg, {F{1'b0}}});

    // output bytes, rounded and saturated
    function automatic logic [7:0] to_byte(input logic [CWD-1:0] c);
        logic [XW-1:0] x;
        logic [9:0]    y;
        x = XW'(c) * XW'(255) + HALF;
        y = x[F+9:F];
        return (y > 10'd255) ? 8'hFF : y[7:0];
    endfunction

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= color_in;
            c0_reg   <= {1'b0, byte_fx[color_in[31:24]]};
            c1_reg   <= {1'b0, byte_fx[color_in[23:16]]};
            c2_reg   <= {1'b0, byte_fx[color_in[15:8]]};
        end
        if (div_done)
        begin
            case (cmd.div_job)
                rca_pkg::JOB_SAT: s_reg <= (hi_reg == '0) ? '0 : quotient;
                default:          h_reg <= (d_reg == '0) ? '0 : quotient;
            endcase
        end
        if (cmd.hue)
        begin
            hi_reg <= hi_c[F:0];
            d_reg  <= dd[F:0];
            n_reg  <= n_c;
            v_reg  <= $signed((F+3)'(hi_c));
        end
        if (cmd.prep)
        begin
            sector_reg <= (sec == 4'd6) ? 3'd0 : sec[2:0];
            a1_reg     <= ONE_C - s_reg;
            a2_reg     <= ONE_C - fs1[2*F:F];
            a3_reg     <= ONE_C - fs2[2*F:F];
        end
        if (cmd.step)
            v_reg <= cmd.dir_up ? v_reg + step_s : v_reg - step_s;
        if (cmd.pqt)
        begin
            vv_reg <= vv_c;
            p_reg  <= mp[2*F+1:F];
            q_reg  <= mq[2*F+1:F];
            t_reg  <= mt[2*F+1:F];
        end
        if (cmd.loadc)
        begin
            case (sector_reg)
                3'd0:    begin c0_reg <= vv_reg; c1_reg <= t_reg;  c2_reg <= p_reg;  end
                3'd1:    begin c0_reg <= q_reg;  c1_reg <= vv_reg; c2_reg <= p_reg;  end
                3'd2:    begin c0_reg <= p_reg;  c1_reg <= vv_reg; c2_reg <= t_reg;  end
                3'd3:    begin c0_reg <= p_reg;  c1_reg <= q_reg;  c2_reg <= vv_reg; end
                3'd4:    begin c0_reg <= t_reg;  c1_reg <= p_reg;  c2_reg <= vv_reg; end
                default: begin c0_reg <= vv_reg; c1_reg <= p_reg;  c2_reg <= q_reg;  end
            endcase
        end
        if (cmd.weigh)
        begin
            pr_reg <= PW'(WR) * PW'(c0_reg);
            pg_reg <= PW'(WG) * PW'(c1_reg);
            pb_reg <= PW'(WB) * PW'(c2_reg);
        end
        if (cmd.sum)
            bright_reg <= bsum[SW-1:F];
        if (cmd.out_load)
            out_reg <= {to_byte(c0_reg), to_byte(c1_reg), to_byte(c2_reg), word_reg[7:0]};
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign color_out     = out_reg;
    assign out_valid     = out_valid_reg;
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.bright_lt = bright_reg < cap_fx;
    assign sts.bright_gt = bright_reg > cap_fx;
    assign sts.v_ok      = !v_reg[F+2] && (v_reg[F+1:0] <= ONE_W);
    assign sts.out_full  = out_valid_reg;

endmodule

// File: design/rca_ctrl.sv
module rca_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rca_pkg::sts_t sts,
    input  logic          out_ready,
    output rca_pkg::cmd_t cmd
);

    rca_pkg::ctrl_state_t state_reg, state_next;
    rca_pkg::div_job_t    job_reg, job_next;
    logic dir_reg, dir_next;
    logic first_reg, first_next;
    logic final_reg, final_next;
    logic up, cont;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rca_pkg::ST_IDLE;
            job_reg   <= rca_pkg::JOB_SAT;
            dir_reg   <= 1'b0;
            first_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            dir_reg   <= dir_next;
            first_reg <= first_next;
            final_reg <= final_next;
        end
    end

    // sequencing of one item
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        dir_next   = dir_reg;
        first_next = first_reg;
        final_next = final_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.div_job = job_reg;
        cmd.dir_up  = dir_reg;
        up   = first_reg ? sts.bright_lt : dir_reg;
        cont = (up ? sts.bright_lt : sts.bright_gt) && sts.v_ok;
        case (state_reg)
            rca_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    final_next = 1'b0;
                    state_next = rca_pkg::ST_HUE;
                end
            end
            rca_pkg::ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = rca_pkg::ST_DIVW;
            end
            rca_pkg::ST_DIVW:
            begin
                if (sts.div_done)
                begin
                    case (job_reg)
                        rca_pkg::JOB_SAT:
                        begin
                            job_next   = rca_pkg::JOB_HUE;
                            state_next = rca_pkg::ST_DIV;
                        end
                        default: state_next = rca_pkg::ST_PREP;
                    endcase
                end
            end
            rca_pkg::ST_HUE:
            begin
                cmd.hue    = 1'b1;
                job_next   = rca_pkg::JOB_SAT;
                state_next = rca_pkg::ST_DIV;
            end
            rca_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                first_next = 1'b1;
                state_next = rca_pkg::ST_WEIGH;
            end
            rca_pkg::ST_WEIGH:
            begin
                cmd.weigh  = 1'b1;
                state_next = rca_pkg::ST_SUM;
            end
            rca_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = rca_pkg::ST_CHECK;
            end
            rca_pkg::ST_CHECK:
            begin
                dir_next   = up;
                first_next = 1'b0;
                if (cont)
                    state_next = rca_pkg::ST_STEP;
                else
                begin
                    final_next = 1'b1;
                    state_next = rca_pkg::ST_PQT;
                end
            end
            rca_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = rca_pkg::ST_PQT;
            end
            rca_pkg::ST_PQT:
            begin
                cmd.pqt    = 1'b1;
                state_next = rca_pkg::ST_LOADC;
            end
            rca_pkg::ST_LOADC:
            begin
                cmd.loadc  = 1'b1;
                state_next = final_reg ? rca_pkg::ST_OUT : rca_pkg::ST_WEIGH;
            end
            rca_pkg::ST_OUT:
            begin
                if (!sts.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rca_pkg::ST_IDLE;
                end
            end
            default: state_next = rca_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: design/readable_color_adjust_unit.sv
// Readability colour adjuster.
// in_ch takes one packed RRGGBBAA item at an edge with valid and ready high;
// out_ch gives the adjusted colour with the same layout, alpha unchanged.
// cfg_we/cfg_index/cfg_data write brightness_cap (index 0, data 7:0) and
// value_step (index 1, data 15:0); write only while the block is idle.
// The saturation and hue divisions run one bit a cycle on the shared
// divider, the channels come from a byte table, and each value step is
// one multiply and weigh pass. One item is processed at a time;
// in_ch.ready is high only between items, so a new item is not taken
// until the current one has been loaded into the output register.
// The finished colour sits in an output register, so the next item can be
// taken while it waits; if the receiver still stalls when the following
// result is done, the controller holds in its output state.
// Reset returns the controller to idle, empties the output register and
// loads brightness_cap 115 and value_step 655.
module readable_color_adjust_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rca_in_if.sink                         in_ch,
    rca_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0] cfg_data
);

    rca_pkg::cmd_t cmd;
    rca_pkg::sts_t sts;
    logic          in_ready;

    // controller
    rca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .sts       (sts),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // datapath
    rca_datapath #(.F(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .color_in  (in_ch.color_in),
        .color_out (out_ch.color_out),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign in_ch.ready = in_ready;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken again straight after an item");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_ch.valid || out_ch.ready))
        else $error("result overwrote a waiting item");

endmodule
